// File: sv/ring_allocator_ooo_free_macros.svh
// Assertion macros for the ring allocator.
// Included by the top level, which supplies clk and rst.
`ifndef RING_ALLOCATOR_OOO_FREE_MACROS_SVH
`define RING_ALLOCATOR_OOO_FREE_MACROS_SVH

// Check an expression at every clock edge outside reset
`define RAO_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define RAO_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define RAO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/rao_pkg.sv
// Shared constants and types for the ring allocator.
// No dependencies.
`default_nettype none

package rao_pkg;

  localparam int RING_SIZE_W = 25;
  localparam int ALIGN_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 25;
  localparam int STATUS_W = 3;
  localparam int PENDING_SLOTS_DEF = 16;
  localparam int OFFSET_BITS_DEF = 24;

  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_MASK = 2'd1;

  localparam logic [RING_SIZE_W-1:0] RING_SIZE_RST = 25'd65536;
  localparam logic [ALIGN_W-1:0] ALIGN_MASK_RST = 16'd255;

  localparam logic [STATUS_W-1:0] STS_GRANTED = 3'd0;
  localparam logic [STATUS_W-1:0] STS_NO_SPACE = 3'd1;
  localparam logic [STATUS_W-1:0] STS_AT_HEAD = 3'd2;
  localparam logic [STATUS_W-1:0] STS_DEFERRED = 3'd3;
  localparam logic [STATUS_W-1:0] STS_TABLE_FULL = 3'd4;

  typedef enum logic [3:0] {
    CTL_IDLE,
    CTL_REQ_ROUND,
    CTL_REQ_PLACE,
    CTL_REL_CHECK,
    CTL_MOD_WAIT,
    CTL_SCAN_RD,
    CTL_SCAN_CMP,
    CTL_SCAN_END,
    CTL_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {
    MOD_IDLE,
    MOD_RUN,
    MOD_DONE
  } mod_state_t;

endpackage

`default_nettype wire

// File: sv/rao_mod_unit.sv
// Bit-serial remainder unit: value modulo divisor, one bit per cycle.
// Depends on rao_pkg.
`default_nettype none

module rao_mod_unit
  import rao_pkg::*;
#(
  parameter int VAL_W = 26,
  parameter int DIV_W = 25
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] value,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIV_W-1:0]      rem
);

  localparam int CNT_W = $clog2(VAL_W + 1);

  mod_state_t       state, state_next;
  logic [VAL_W-1:0] shreg;
  logic [DIV_W-1:0] div_q;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   trial;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      MOD_IDLE: if (start) state_next = MOD_RUN;
      MOD_RUN:  if (cnt == CNT_W'(1)) state_next = MOD_DONE;
      MOD_DONE: state_next = MOD_IDLE;
      default:  state_next = MOD_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy = (state != MOD_IDLE);
    done = (state == MOD_DONE);
  end

  assign trial = {rem, shreg[VAL_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MOD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Shift in one bit, subtract when the partial remainder reaches the divisor
  always_ff @(posedge clk) begin
    if (state == MOD_IDLE && start) begin
      shreg <= value;
      div_q <= divisor;
      cnt <= CNT_W'(VAL_W);
      rem <= '0;
    end else if (state == MOD_RUN) begin
      shreg <= shreg << 1;
      cnt <= cnt - 1'b1;
      if (trial >= {1'b0, div_q}) begin
        rem <= DIV_W'(trial - {1'b0, div_q});
      end else begin
        rem <= trial[DIV_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/rao_pend_mem.sv
// Pending release table storage: start and size of each parked release.
// One write port, one registered read port. Depends on rao_pkg.
`default_nettype none

module rao_pend_mem
  import rao_pkg::*;
#(
  parameter int PENDING_SLOTS = PENDING_SLOTS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                                           clk,
  input  wire logic                                           we,
  input  wire logic [(PENDING_SLOTS > 1 ? $clog2(PENDING_SLOTS) : 1)-1:0] waddr,
  input  wire logic [2*OFFSET_BITS:0]                         wdata,
  input  wire logic                                           re,
  input  wire logic [(PENDING_SLOTS > 1 ? $clog2(PENDING_SLOTS) : 1)-1:0] raddr,
  output logic [2*OFFSET_BITS:0]                              rdata
);

  logic [2*OFFSET_BITS:0] mem [PENDING_SLOTS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/ring_allocator_ooo_free.sv
// Ring allocator, one item at a time: a request passes accept, round, place and output.
// A release passes accept, check, table passes, an end step and output; a pass reads
// each pending slot and compares each valid one (a deferred start match ends the pass
// and skips the end step); each bit-serial head advance comes before a new pass.
// Reset (and a ring_size write) empties the ring at once; no clearing pass.
// Depends on rao_pkg, rao_mod_unit, rao_pend_mem and the macros header.
`default_nettype none

`include "ring_allocator_ooo_free_macros.svh"

module ring_allocator_ooo_free
  import rao_pkg::*;
#(
  parameter int PENDING_SLOTS = PENDING_SLOTS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // tdata: req_bytes, rel_start, rel_bytes (lowest bit up)
  input  wire logic [((3*OFFSET_BITS+2+7)/8)*8-1:0]   s_axis_tdata,
  // tuser: command
  input  wire logic                                    s_axis_tuser,
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  // tdata: data_offset, record_start, record_bytes, ring_empty (lowest bit up)
  output logic [((3*OFFSET_BITS+2+7)/8)*8-1:0]        m_axis_tdata,
  // tuser: status
  output logic [STATUS_W-1:0]                          m_axis_tuser,
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  input  wire logic                                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]                    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]                   cfg_data
);

  localparam int OB = OFFSET_BITS;
  localparam int SZW = OB + 1;
  localparam int TDW = ((3*OB+2+7)/8)*8;
  localparam int IW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int CW = (SZW > RING_SIZE_W) ? SZW : RING_SIZE_W;
  localparam int RQW = ((SZW > ALIGN_W) ? SZW : ALIGN_W) + 1;
  localparam int PW = ((RQW > SZW) ? RQW : SZW) + 1;
  localparam int VW = OB + 2;
  localparam logic [IW-1:0] LAST = IW'(PENDING_SLOTS - 1);

  // Clamp a ring size to 1 .. 2^OFFSET_BITS
  function automatic logic [SZW-1:0] eff_of(input logic [RING_SIZE_W-1:0] v);
    logic [CW-1:0] ve;
    logic [CW-1:0] cap;
    ve = CW'(v);
    cap = CW'(1) << OB;
    if (v == '0) begin
      eff_of = SZW'(1);
    end else if (ve > cap) begin
      eff_of = cap[SZW-1:0];
    end else begin
      eff_of = ve[SZW-1:0];
    end
  endfunction

  ctl_state_t state, state_next;

  logic [RING_SIZE_W-1:0] ring_size;
  logic [ALIGN_W-1:0]     align_mask;
  logic [SZW-1:0]         eff_size;
  logic [OB-1:0]          head, tail;
  logic [SZW-1:0]         remaining;
  logic [PENDING_SLOTS-1:0] valid;

  logic [SZW-1:0]         req_q;
  logic [OB-1:0]          rstart_q;
  logic [SZW-1:0]         rbytes_q;
  logic [RQW-1:0]         rs_q;

  logic [IW-1:0]          idx, free_idx;
  logic                   free_found, merging;
  logic [SZW-1:0]         add_q;

  logic [STATUS_W-1:0]    res_status;
  logic [OB-1:0]          res_data, res_rstart;
  logic [SZW-1:0]         res_rbytes;

  logic                   in_xfer, out_free;
  logic                   mem_we, mem_re;
  logic [IW-1:0]          mem_waddr;
  logic [2*OB:0]          mem_rdata;
  logic [OB-1:0]          rd_start;
  logic [SZW-1:0]         rd_bytes;
  logic                   rd_match;

  logic                   mod_start, mod_busy, mod_done;
  logic [VW-1:0]          mod_val;
  logic [SZW-1:0]         mod_rem;

  logic [PW-1:0] rs_e, rem_e, size_e, tail_e, gap_e, sum_t, tail_adv, charged;
  logic          no_space, fit_tail, fit_wrap;
  logic [SZW:0]  sat_sum;

  assign eff_size = eff_of(ring_size);
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign rd_start = mem_rdata[OB-1:0];
  assign rd_bytes = mem_rdata[2*OB:OB];
  assign rd_match = merging ? (rd_start == head) : (rd_start == rstart_q);

  // Placement arithmetic for a rounded request
  always_comb begin
    rs_e = PW'(rs_q);
    rem_e = PW'(remaining);
    size_e = PW'(eff_size);
    tail_e = PW'(tail);
    gap_e = size_e - tail_e;
    sum_t = tail_e + rs_e;
    tail_adv = (sum_t >= size_e) ? (sum_t - size_e) : sum_t;
    charged = rs_e + gap_e;
    no_space = rem_e < rs_e;
    fit_tail = (tail < head) || (gap_e >= rs_e);
    fit_wrap = (rem_e >= gap_e) && ((rem_e - gap_e) >= rs_e);
  end

  // Saturating add of released bytes
  assign sat_sum = {1'b0, remaining} + {1'b0, add_q};

  // Operand of the head advance
  assign mod_val = (state == CTL_REL_CHECK) ? (VW'(head) + VW'(rbytes_q))
                                            : (VW'(head) + VW'(rd_bytes));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      CTL_IDLE: begin
        if (in_xfer) state_next = s_axis_tuser ? CTL_REL_CHECK : CTL_REQ_ROUND;
      end
      CTL_REQ_ROUND: state_next = CTL_REQ_PLACE;
      CTL_REQ_PLACE: state_next = CTL_OUT;
      CTL_REL_CHECK: state_next = (rstart_q == head) ? CTL_MOD_WAIT : CTL_SCAN_RD;
      CTL_MOD_WAIT:  if (mod_done) state_next = CTL_SCAN_RD;
      CTL_SCAN_RD: begin
        if (valid[idx]) state_next = CTL_SCAN_CMP;
        else if (idx == LAST) state_next = CTL_SCAN_END;
      end
      CTL_SCAN_CMP: begin
        if (rd_match) state_next = merging ? CTL_MOD_WAIT : CTL_OUT;
        else if (idx == LAST) state_next = CTL_SCAN_END;
        else state_next = CTL_SCAN_RD;
      end
      CTL_SCAN_END: state_next = CTL_OUT;
      CTL_OUT:      if (out_free) state_next = CTL_IDLE;
      default:      state_next = CTL_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready = (state == CTL_IDLE);
    mem_re = (state == CTL_SCAN_RD) && valid[idx];
    mod_start = ((state == CTL_REL_CHECK) && (rstart_q == head)) ||
                ((state == CTL_SCAN_CMP) && rd_match && merging);
    mem_we = ((state == CTL_SCAN_CMP) && rd_match && !merging) ||
             ((state == CTL_SCAN_END) && !merging && free_found);
    mem_waddr = (state == CTL_SCAN_CMP) ? idx : free_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Registers, ring pointers and pending valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= RING_SIZE_RST;
      align_mask <= ALIGN_MASK_RST;
      head <= '0;
      tail <= '0;
      remaining <= eff_of(RING_SIZE_RST);
      valid <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_RING_SIZE) begin
        ring_size <= cfg_data;
        head <= '0;
        tail <= '0;
        remaining <= eff_of(cfg_data);
        valid <= '0;
      end else begin
        if (cfg_we && cfg_index == REG_ALIGN_MASK) begin
          align_mask <= cfg_data[ALIGN_W-1:0];
        end
        case (state)
          CTL_REQ_PLACE: begin
            if (!no_space && fit_tail) begin
              tail <= tail_adv[OB-1:0];
              remaining <= SZW'(rem_e - rs_e);
            end else if (!no_space && fit_wrap) begin
              tail <= (rs_e == size_e) ? '0 : rs_e[OB-1:0];
              remaining <= SZW'(rem_e - charged);
            end
          end
          CTL_MOD_WAIT: begin
            if (mod_done) begin
              head <= mod_rem[OB-1:0];
              remaining <= (sat_sum > {1'b0, eff_size}) ? eff_size : sat_sum[SZW-1:0];
            end
          end
          CTL_SCAN_CMP: begin
            if (rd_match && merging) valid[idx] <= 1'b0;
          end
          CTL_SCAN_END: begin
            if (!merging && free_found) valid[free_idx] <= 1'b1;
          end
          default: ;
        endcase
      end
      // Raise on a new result, drop once the result transfers
      if (state == CTL_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Item fields, scan bookkeeping and result
  always_ff @(posedge clk) begin
    case (state)
      CTL_IDLE: begin
        if (in_xfer) begin
          req_q <= s_axis_tdata[SZW-1:0];
          rstart_q <= s_axis_tdata[SZW+OB-1:SZW];
          rbytes_q <= s_axis_tdata[2*SZW+OB-1:SZW+OB];
          res_data <= '0;
          res_rstart <= '0;
          res_rbytes <= '0;
        end
      end
      CTL_REQ_ROUND: begin
        rs_q <= (RQW'(req_q) + RQW'(align_mask)) & ~RQW'(align_mask);
      end
      CTL_REQ_PLACE: begin
        if (!no_space && fit_tail) begin
          res_status <= STS_GRANTED;
          res_data <= tail;
          res_rstart <= tail;
          res_rbytes <= rs_e[SZW-1:0];
        end else if (!no_space && fit_wrap) begin
          res_status <= STS_GRANTED;
          res_data <= '0;
          res_rstart <= tail;
          res_rbytes <= charged[SZW-1:0];
        end else begin
          res_status <= STS_NO_SPACE;
        end
      end
      CTL_REL_CHECK: begin
        idx <= '0;
        free_found <= 1'b0;
        merging <= (rstart_q == head);
        add_q <= rbytes_q;
      end
      CTL_MOD_WAIT: begin
        if (mod_done) idx <= '0;
      end
      CTL_SCAN_RD: begin
        if (!valid[idx]) begin
          if (!free_found) begin
            free_found <= 1'b1;
            free_idx <= idx;
          end
          if (idx != LAST) idx <= idx + 1'b1;
        end
      end
      CTL_SCAN_CMP: begin
        if (rd_match) begin
          add_q <= rd_bytes;
          if (!merging) res_status <= STS_DEFERRED;
        end else if (idx != LAST) begin
          idx <= idx + 1'b1;
        end
      end
      CTL_SCAN_END: begin
        if (merging) res_status <= STS_AT_HEAD;
        else if (free_found) res_status <= STS_DEFERRED;
        else res_status <= STS_TABLE_FULL;
      end
      CTL_OUT: begin
        if (out_free) begin
          m_axis_tuser <= res_status;
          m_axis_tdata <= TDW'({remaining == eff_size, res_rbytes, res_rstart, res_data});
        end
      end
      default: ;
    endcase
  end

  rao_pend_mem #(
    .PENDING_SLOTS(PENDING_SLOTS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_pend_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata({rbytes_q, rstart_q}),
    .re(mem_re),
    .raddr(idx),
    .rdata(mem_rdata)
  );

  rao_mod_unit #(
    .VAL_W(VW),
    .DIV_W(SZW)
  ) u_mod_unit (
    .clk(clk),
    .rst(rst),
    .start(mod_start),
    .value(mod_val),
    .divisor(eff_size),
    .busy(mod_busy),
    .done(mod_done),
    .rem(mod_rem)
  );

  // Consistency checks
  `RAO_ASSERT_ALWAYS(a_rem_bound, remaining <= eff_size, "remaining exceeds ring size")
  `RAO_ASSERT_ALWAYS(a_ptr_bound, SZW'(head) < eff_size && SZW'(tail) < eff_size, "bad pointer")
  `RAO_ASSERT_IMPL(a_busy_no_accept, mod_busy, !s_axis_tready, "input taken during head advance")
  `RAO_ASSERT_NEXT(a_one_item, in_xfer, !s_axis_tready, "second item taken while one in work")

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the ring allocator with out-of-order release.
// Depends on rao_pkg and ring_allocator_ooo_free; predicts each result in order.
`timescale 1ns / 100ps

module testbench;
  import rao_pkg::*;

  localparam int OFS_W = 24;
  localparam int DATA_W = ((3*OFS_W+2+7)/8)*8;
  localparam longint unsigned RING_CAP = 64'd1 << OFS_W;
  localparam int SLOTS = 16;
  localparam longint CYCLE_LIMIT = 10000000;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [23:0] data_ofs;
    logic [23:0] rec_start;
    logic [24:0] rec_bytes;
    logic empty;
  } alloc_result_t;

  typedef struct {
    longint unsigned start;
    longint unsigned bytes;
  } region_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ring_allocator_ooo_free dut (
    .clk(clk), .rst(rst),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Allocator shadow state
  logic [24:0] ring_reg;
  logic [15:0] mask_reg;
  longint unsigned head_ofs, tail_ofs, free_bytes;
  logic park_valid [SLOTS];
  longint unsigned park_start [SLOTS];
  longint unsigned park_bytes [SLOTS];

  alloc_result_t pending_results[$];
  region_t live_regions[$];
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int grants = 0, refusals = 0, head_frees = 0, parked = 0, table_full = 0;
  int hold_left = 0;
  bit calm = 1'b0;
  longint cycles = 0;

  function automatic longint unsigned ring_bytes();
    if (ring_reg == 0) return 1;
    return (ring_reg > RING_CAP) ? RING_CAP : 64'(ring_reg);
  endfunction

  function automatic void clear_ring();
    head_ofs = 0;
    tail_ofs = 0;
    free_bytes = ring_bytes();
    for (int i = 0; i < SLOTS; i++) park_valid[i] = 1'b0;
    live_regions.delete();
  endfunction

  function automatic void give_back(longint unsigned n);
    free_bytes += n;
    if (free_bytes > ring_bytes()) free_bytes = ring_bytes();
  endfunction

  // Compute the result of one item and advance the shadow state
  function automatic alloc_result_t predict_alloc(logic cmd, longint unsigned req,
                                                  longint unsigned rstart,
                                                  longint unsigned rbytes);
    alloc_result_t r;
    longint unsigned size, m, rsz, gap;
    int free_slot;
    bit merged, done;
    size = ring_bytes();
    r = '{STS_NO_SPACE, '0, '0, '0, 1'b0};
    if (cmd == CMD_REQUEST) begin
      m = 64'(mask_reg);
      rsz = (req + m) & ~m;
      gap = size - tail_ofs;
      if (free_bytes < rsz) begin
        r.status = STS_NO_SPACE;
      end else if (tail_ofs < head_ofs || gap >= rsz) begin
        r = '{STS_GRANTED, tail_ofs[23:0], tail_ofs[23:0], rsz[24:0], 1'b0};
        tail_ofs += rsz;
        if (tail_ofs >= size) tail_ofs -= size;
        free_bytes -= rsz;
      end else if (free_bytes >= gap && free_bytes - gap >= rsz) begin
        r = '{STS_GRANTED, 24'd0, tail_ofs[23:0], 25'(rsz + gap), 1'b0};
        tail_ofs = rsz % size;
        free_bytes -= rsz + gap;
      end
    end else if (rstart == head_ofs) begin
      r.status = STS_AT_HEAD;
      head_ofs = (head_ofs + rbytes) % size;
      give_back(rbytes);
      do begin
        merged = 1'b0;
        for (int i = 0; i < SLOTS && !merged; i++) begin
          if (park_valid[i] && park_start[i] == head_ofs) begin
            head_ofs = (head_ofs + park_bytes[i]) % size;
            give_back(park_bytes[i]);
            park_valid[i] = 1'b0;
            merged = 1'b1;
          end
        end
      end while (merged);
    end else begin
      free_slot = -1;
      done = 1'b0;
      for (int i = 0; i < SLOTS && !done; i++) begin
        if (park_valid[i] && park_start[i] == rstart) begin
          park_bytes[i] = rbytes;
          done = 1'b1;
        end else if (!park_valid[i] && free_slot < 0) begin
          free_slot = i;
        end
      end
      if (done) begin
        r.status = STS_DEFERRED;
      end else if (free_slot < 0) begin
        r.status = STS_TABLE_FULL;
      end else begin
        park_valid[free_slot] = 1'b1;
        park_start[free_slot] = rstart;
        park_bytes[free_slot] = rbytes;
        r.status = STS_DEFERRED;
      end
    end
    r.empty = (free_bytes == size);
    return r;
  endfunction

  // Offer one item, predict it, and hold it until the transfer
  task automatic send_item(logic cmd, logic [24:0] req, logic [23:0] rstart,
                           logic [24:0] rbytes);
    alloc_result_t r;
    if (!calm && $urandom_range(99) < 15) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tdata = '0;
    s_axis_tdata[24:0] = req;
    s_axis_tdata[48:25] = rstart;
    s_axis_tdata[73:49] = rbytes;
    s_axis_tuser = cmd;
    s_axis_tvalid = 1'b1;
    r = predict_alloc(cmd, 64'(req), 64'(rstart), 64'(rbytes));
    if (cmd == CMD_REQUEST && r.status == STS_GRANTED)
      live_regions.push_back('{64'(r.rec_start), 64'(r.rec_bytes)});
    pending_results.push_back(r);
    items_sent++;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_RING_SIZE) begin
      ring_reg = val;
      clear_ring();
    end else if (idx == REG_ALIGN_MASK) begin
      mask_reg = val[15:0];
    end
  endtask

  task automatic release_region(int k);
    region_t g;
    g = live_regions[k];
    live_regions.delete(k);
    send_item(CMD_RELEASE, '0, g.start[23:0], g.bytes[24:0]);
  endtask

  // Mostly well-formed traffic: requests and out-of-order releases, some noise
  task automatic run_traffic(int n, longint unsigned max_req);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_item(CMD_REQUEST, 25'($urandom), 24'($urandom), 25'($urandom));
      end else if (pick < 12) begin
        send_item(CMD_RELEASE, 25'($urandom), 24'($urandom),
                  25'($urandom_range(32'(max_req))));
      end else if (pick < 55 || live_regions.size() == 0) begin
        send_item(CMD_REQUEST, 25'($urandom_range(32'(max_req))), 24'($urandom),
                  25'($urandom));
      end else if (pick < 70) begin
        release_region(0);
      end else begin
        release_region(int'($urandom_range(live_regions.size() - 1)));
      end
    end
  endtask

  // Default registers: zero size, rounding, head release, oversized release
  task automatic test_defaults();
    send_item(CMD_REQUEST, 25'd0, '0, '0);
    send_item(CMD_REQUEST, 25'd100, '0, '0);
    send_item(CMD_REQUEST, 25'h1FFFFFF, '0, '0);
    send_item(CMD_RELEASE, '0, 24'd0, 25'd256);
    send_item(CMD_RELEASE, '0, 24'hFFFFFF, 25'h1FFFFFF);
    send_item(CMD_RELEASE, '0, 24'd256, 25'h1FFFFFF);
  endtask

  // Wrap placement, refusal, repeated parked start and a full pending table
  task automatic test_special_cases();
    write_reg(REG_RING_SIZE, 25'd1000);
    write_reg(REG_ALIGN_MASK, 25'h005A);
    send_item(CMD_REQUEST, 25'd300, '0, '0);
    send_item(CMD_REQUEST, 25'd500, '0, '0);
    send_item(CMD_REQUEST, 25'd150, '0, '0);
    send_item(CMD_RELEASE, '0, 24'd0, 25'd400);
    send_item(CMD_REQUEST, 25'd200, '0, '0);
    send_item(CMD_RELEASE, '0, 24'd900, 25'd10);
    send_item(CMD_RELEASE, '0, 24'd900, 25'd20);
    for (int i = 1; i <= SLOTS + 1; i++)
      send_item(CMD_RELEASE, '0, 24'(i), 25'd1);
    send_item(CMD_REQUEST, 25'd5000, '0, '0);
  endtask

  // Ring size and mask extremes, plus an unused register index
  task automatic test_register_extremes();
    logic [CFG_DATA_W-1:0] sizes [5] = '{25'd0, 25'd1, 25'h1FFFFFF, 25'h1000000, 25'd4096};
    logic [15:0] masks [3] = '{16'd0, 16'hFFFF, 16'd3};
    write_reg(REG_SPARE, 25'h1FFFFFF);
    foreach (sizes[i]) begin
      write_reg(REG_RING_SIZE, sizes[i]);
      write_reg(REG_ALIGN_MASK, CFG_DATA_W'(masks[i % 3]));
      send_item(CMD_REQUEST, 25'd1, '0, '0);
      send_item(CMD_REQUEST, 25'h0FFFFFF, '0, '0);
      send_item(CMD_RELEASE, '0, 24'd0, 25'd1);
    end
  endtask

  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] sizes [6] = '{25'd4096, 25'd1000, 25'd65536, 25'd777, 25'd300,
                                         25'h1000000};
    logic [15:0] masks [6] = '{16'd63, 16'd0, 16'd255, 16'd7, 16'h0F0F, 16'd4095};
    foreach (sizes[i]) begin
      write_reg(REG_RING_SIZE, sizes[i]);
      write_reg(REG_ALIGN_MASK, CFG_DATA_W'(masks[i]));
      calm = (i == 2);
      run_traffic(275, 64'(sizes[i] / 5));
      calm = 1'b0;
    end
  endtask

  // Stall the result side long enough to back up the input, drain fully, then send more
  task automatic test_backpressure();
    write_reg(REG_RING_SIZE, 25'd2048);
    write_reg(REG_ALIGN_MASK, 25'd15);
    hold_left = 400;
    run_traffic(30, 300);
    drain();
    run_traffic(30, 300);
  endtask

  // Result side: random stalls, or a counted hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || $urandom_range(99) >= 15;
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at cycle %0d", cycles);
      end else begin
        e = pending_results.pop_front();
        case (e.status)
          STS_GRANTED: grants++;
          STS_NO_SPACE: refusals++;
          STS_AT_HEAD: head_frees++;
          STS_DEFERRED: parked++;
          default: table_full++;
        endcase
        if (m_axis_tuser !== e.status || m_axis_tdata[23:0] !== e.data_ofs ||
            m_axis_tdata[47:24] !== e.rec_start || m_axis_tdata[72:48] !== e.rec_bytes ||
            m_axis_tdata[73] !== e.empty) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch #%0d: exp sts=%0d ofs=%0d start=%0d bytes=%0d empty=%0d",
                     results_seen, e.status, e.data_ofs, e.rec_start, e.rec_bytes, e.empty);
            $display("  got sts=%0d ofs=%0d start=%0d bytes=%0d empty=%0d",
                     m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[47:24],
                     m_axis_tdata[72:48], m_axis_tdata[73]);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    ring_reg = RING_SIZE_RST;
    mask_reg = ALIGN_MASK_RST;
    clear_ring();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_defaults();
    test_special_cases();
    test_register_extremes();
    test_random_phases();
    test_backpressure();
    drain();
    $display("%0d items: %0d grants, %0d refusals, %0d head frees, %0d parked, %0d table full",
             items_sent, grants, refusals, head_frees, parked, table_full);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
